### hdl/permuted_stride_address_generator_core_defines.svh
// assertion macros shared by the address generator rtl
`ifndef PERMUTED_STRIDE_ADDRESS_GENERATOR_CORE_DEFINES_SVH
`define PERMUTED_STRIDE_ADDRESS_GENERATOR_CORE_DEFINES_SVH

// same-cycle implication, sampled on clock, off during reset
`define PSAG_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("psag assertion failed");

// next-cycle implication, sampled on clock, off during reset
`define PSAG_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("psag assertion failed");

`endif

### hdl/psag_pkg.sv
// types, constants and helpers of the permuted stride address generator
package psag_pkg;

   localparam int MAX_RANK     = 4;
   localparam int ADDR_W       = 16;
   localparam int COUNT_W      = 16;
   localparam int EXT_W        = 16;
   localparam int STRIDE_W     = 16;
   localparam int PROD_W       = EXT_W + STRIDE_W;
   localparam int AXIS_SEL_W   = 2;
   localparam int NUM_SRC_AXES = 4;
   localparam int ORDER_W      = 8;
   localparam int RANK_REG_W   = 3;
   localparam int RANK_W       = $clog2(MAX_RANK + 1);
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 64;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_RANK    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ORDER   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_EXTENTS = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_STRIDES = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE    = 3'd4;

   // register reset values
   localparam logic [RANK_REG_W-1:0]             RANK_RESET    = 3'd1;
   localparam logic [ORDER_W-1:0]                ORDER_RESET   = 8'd228;
   localparam logic [NUM_SRC_AXES*EXT_W-1:0]     EXTENTS_RESET = 64'h0001_0001_0001_0001;
   localparam logic [NUM_SRC_AXES*STRIDE_W-1:0]  STRIDES_RESET = 64'h0;
   localparam logic [ADDR_W-1:0]                 BASE_RESET    = '0;

   typedef struct packed {
      logic [ADDR_W-1:0]  source_offset;
      logic [COUNT_W-1:0] dest_index;
      logic               last_element;
   } result_type;

   // per output axis settings, derived from the raw registers
   typedef struct packed {
      logic [MAX_RANK-1:0]                active;
      logic [MAX_RANK-1:0]                top;
      logic [ADDR_W-1:0]                  base;
      logic [MAX_RANK-1:0][EXT_W-1:0]     ext_m1;
      logic [MAX_RANK-1:0][ADDR_W-1:0]    stride;
      logic [MAX_RANK-1:0][ADDR_W-1:0]    wrap;
   } axis_cfg_type;

   // source axis of output axis i; axes past the order field read zero
   function automatic logic [AXIS_SEL_W-1:0] src_axis(input logic [ORDER_W-1:0] order,
                                                      input int i);
      logic [AXIS_SEL_W-1:0] sel;
      sel = '0;
      if ((AXIS_SEL_W * i + AXIS_SEL_W) <= ORDER_W)
         sel = order[AXIS_SEL_W*i +: AXIS_SEL_W];
      return sel;
   endfunction

endpackage

### hdl/psag_req_if.sv
// request channel: one word asks for the next element
interface psag_req_if ();
   logic valid;
   logic ready;
   logic restart;

   modport source (output valid, output restart, input ready);
   modport sink (input valid, input restart, output ready);
endinterface

### hdl/psag_rsp_if.sv
// response channel: one address word per request
interface psag_rsp_if import psag_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [ADDR_W-1:0]  source_offset;
   logic [COUNT_W-1:0] dest_index;
   logic               last_element;

   modport source (output valid, output source_offset, output dest_index,
                   output last_element, input ready);
   modport sink (input valid, input source_offset, input dest_index,
                 input last_element, output ready);
endinterface

### hdl/psag_csr_if.sv
// register write channel
interface psag_csr_if import psag_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

### hdl/permuted_stride_address_generator_core.sv
// Permuted stride address generator, top level.
// Walks a tensor of up to four axes in the order of an axis-permuted copy.
// req channel: one word per element wanted; restart=1 begins again at element
//   zero and the base offset before this element is issued.
// rsp channel: source_offset, dest_index and last_element for each request.
// csr channel: register writes (rank, axis order, extents, strides, base);
//   always ready. Writes belong to idle periods and act on the next element.
// Latency: valid the cycle after acceptance unless an older response stalls.
// Throughput: one element per cycle while req.ready is high; the whole carry
//   over the four axis counters is combinational, state to output registers.
// The per-axis wrap amounts (extent-1)*stride come from a registered
//   multiplier stage, so req is held off while settle is set: in the cycle
//   after each csr write and in the cycle after reset.
// Stall: a two-word output buffer lets a request be taken while a response
//   waits; req.ready drops when both words are held or while settle is set.
// Reset: registers return to rank 1, identity order, unit extents, zero
//   strides and base; the walk starts at element zero.
`include "permuted_stride_address_generator_core_defines.svh"
module permuted_stride_address_generator_core import psag_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   psag_req_if.sink   req,
   psag_rsp_if.source rsp,
   psag_csr_if.sink   csr
);

   axis_cfg_type cfg;
   logic         settle;
   result_type   result;
   logic         req_fire;
   logic         rsp_fire;
   logic         csr_fire;

   result_type   out_ff;
   result_type   out_in;
   logic         out_valid_ff;
   logic         out_valid_in;
   result_type   skid_ff;
   result_type   skid_in;
   logic         skid_valid_ff;
   logic         skid_valid_in;

   assign csr.ready = 1'b1;
   assign csr_fire  = csr.valid & csr.ready;
   assign req.ready = ~skid_valid_ff & ~settle;
   assign req_fire  = req.valid & req.ready;
   assign rsp_fire  = out_valid_ff & rsp.ready;

   psag_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_fire),
      .wr_index (csr.index),
      .wr_data  (csr.data),
      .cfg      (cfg),
      .settle   (settle)
   );

   psag_walk u_walk (
      .clock   (clock),
      .reset   (reset),
      .step    (req_fire),
      .restart (req.restart),
      .cfg     (cfg),
      .result  (result)
   );

   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (rsp_fire) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else begin
         if (rsp_fire)
            out_valid_in = 1'b0;
         if (req_fire) begin
            if (!out_valid_ff || rsp_fire) begin
               out_in       = result;
               out_valid_in = 1'b1;
            end else begin
               // response still waiting: park the new word
               skid_in       = result;
               skid_valid_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   assign rsp.valid         = out_valid_ff;
   assign rsp.source_offset = out_ff.source_offset;
   assign rsp.dest_index    = out_ff.dest_index;
   assign rsp.last_element  = out_ff.last_element;

   `PSAG_ASSERT_SAME(a_skid_behind_out, skid_valid_ff, out_valid_ff)
   `PSAG_ASSERT_NEXT(a_accept_gives_rsp, req_fire, out_valid_ff)
   `PSAG_ASSERT_NEXT(a_no_accept_after_csr, csr_fire, !(req.valid && req.ready))
   `PSAG_ASSERT_NEXT(a_restart_count_zero, req_fire && req.restart && !out_valid_ff,
                     rsp.dest_index == '0)

endmodule

### hdl/psag_csr.sv
// configuration registers and per-axis derived settings
module psag_csr import psag_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  wr_en,
   input  logic [CSR_IDX_W-1:0]  wr_index,
   input  logic [CSR_DATA_W-1:0] wr_data,
   output axis_cfg_type          cfg,
   output logic                  settle
);

   logic [RANK_REG_W-1:0]            rank_ff;
   logic [ORDER_W-1:0]               order_ff;
   logic [NUM_SRC_AXES*EXT_W-1:0]    extents_ff;
   logic [NUM_SRC_AXES*STRIDE_W-1:0] strides_ff;
   logic [ADDR_W-1:0]                base_ff;
   logic                             settle_ff;
   axis_cfg_type                     cfg_ff;
   axis_cfg_type                     cfg_in;
   logic [RANK_W-1:0]                rank_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rank_ff    <= RANK_RESET;
         order_ff   <= ORDER_RESET;
         extents_ff <= EXTENTS_RESET;
         strides_ff <= STRIDES_RESET;
         base_ff    <= BASE_RESET;
      end else if (wr_en) begin
         case (wr_index)
            CSR_RANK:    rank_ff    <= wr_data[RANK_REG_W-1:0];
            CSR_ORDER:   order_ff   <= wr_data[ORDER_W-1:0];
            CSR_EXTENTS: extents_ff <= wr_data[NUM_SRC_AXES*EXT_W-1:0];
            CSR_STRIDES: strides_ff <= wr_data[NUM_SRC_AXES*STRIDE_W-1:0];
            CSR_BASE:    base_ff    <= wr_data[ADDR_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      logic [AXIS_SEL_W-1:0] src;
      logic [EXT_W-1:0]      ext;
      logic [EXT_W-1:0]      ext_m1;
      logic [STRIDE_W-1:0]   stride;
      logic [PROD_W-1:0]     prod;
      if (rank_ff == '0)
         rank_eff = RANK_W'(1);
      else if (int'(rank_ff) > MAX_RANK)
         rank_eff = RANK_W'(MAX_RANK);
      else
         rank_eff = RANK_W'(rank_ff);
      cfg_in.base = base_ff;
      for (int i = 0; i < MAX_RANK; i++) begin
         src    = src_axis(order_ff, i);
         ext    = extents_ff[int'(src)*EXT_W +: EXT_W];
         stride = strides_ff[int'(src)*STRIDE_W +: STRIDE_W];
         // zero extent counts as one
         ext_m1 = (ext == '0) ? '0 : ext - EXT_W'(1);
         prod   = PROD_W'(ext_m1) * PROD_W'(stride);
         cfg_in.active[i] = (i < int'(rank_eff));
         cfg_in.top[i]    = (i == int'(rank_eff) - 1);
         cfg_in.ext_m1[i] = ext_m1;
         cfg_in.stride[i] = ADDR_W'(stride);
         cfg_in.wrap[i]   = prod[ADDR_W-1:0];
      end
   end

   // derived settings are registered from the raw registers
   always_ff @(posedge clock) begin
      cfg_ff <= cfg_in;
      if (reset)
         settle_ff <= 1'b1;
      else
         settle_ff <= wr_en;
   end

   assign cfg    = cfg_ff;
   assign settle = settle_ff;

endmodule

### hdl/psag_walk.sv
// walk state: per-axis index counters, running offset and element count
module psag_walk import psag_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         step,
   input  logic         restart,
   input  axis_cfg_type cfg,
   output result_type   result
);

   logic [MAX_RANK-1:0][EXT_W-1:0] pos_ff;
   logic [MAX_RANK-1:0][EXT_W-1:0] pos_in;
   logic [ADDR_W-1:0]              offset_ff;
   logic [ADDR_W-1:0]              offset_in;
   logic [COUNT_W-1:0]             count_ff;
   logic [COUNT_W-1:0]             count_in;

   logic [MAX_RANK-1:0][EXT_W-1:0] pos_cur;
   logic [ADDR_W-1:0]              offset_cur;
   logic [COUNT_W-1:0]             count_cur;
   logic [MAX_RANK-1:0]            full;
   logic [MAX_RANK-1:0]            reach;
   logic [MAX_RANK-1:0]            wraps;
   logic                           last;

   always_comb begin
      logic [ADDR_W-1:0] acc;
      pos_cur    = restart ? '0 : pos_ff;
      offset_cur = restart ? cfg.base : offset_ff;
      count_cur  = restart ? '0 : count_ff;
      for (int i = 0; i < MAX_RANK; i++)
         full[i] = (pos_cur[i] >= cfg.ext_m1[i]);
      last = &(full | ~cfg.active);

      // step enters at the innermost active axis and carries outward
      acc = offset_cur;
      for (int i = MAX_RANK - 1; i >= 0; i--) begin
         reach[i] = cfg.top[i];
         if (i < MAX_RANK - 1)
            reach[i] = reach[i] | wraps[i+1];
         wraps[i] = reach[i] & full[i] & (i > 0);
         if (wraps[i]) begin
            acc       = acc - cfg.wrap[i];
            pos_in[i] = '0;
         end else if (reach[i]) begin
            acc       = acc + cfg.stride[i];
            pos_in[i] = pos_cur[i] + EXT_W'(1);
         end else begin
            pos_in[i] = pos_cur[i];
         end
      end
      offset_in = acc;
      count_in  = count_cur + COUNT_W'(1);

      // past the last element the walk starts over
      if (last) begin
         pos_in    = '0;
         offset_in = cfg.base;
         count_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         offset_ff <= '0;
         count_ff  <= '0;
      end else if (step) begin
         pos_ff    <= pos_in;
         offset_ff <= offset_in;
         count_ff  <= count_in;
      end
   end

   assign result.source_offset = offset_cur;
   assign result.dest_index    = count_cur;
   assign result.last_element  = last;

endmodule
